// ===== hw/rtl/bdrb_pkg.sv =====
// ============================================================================
// bdrb_pkg
// Shared types and constants for the bidirectional direction run builder.
// ============================================================================
package bdrb_pkg;

    // Depth of the result queue; it must be at least two.
    localparam int unsigned RB_QUEUE_DEPTH = 4;

    // Code point bounds of the right-to-left ranges.
    localparam logic [20:0] CP_HEB_ARAB_LO = 21'h00590;
    localparam logic [20:0] CP_HEB_ARAB_HI = 21'h008FF;
    localparam logic [20:0] CP_PRES_A_LO   = 21'h0FB1D;
    localparam logic [20:0] CP_PRES_A_HI   = 21'h0FDFF;
    localparam logic [20:0] CP_PRES_B_LO   = 21'h0FE70;
    localparam logic [20:0] CP_PRES_B_HI   = 21'h0FEFF;

    // Code points that take the base direction.
    localparam logic [20:0] CP_NUL   = 21'h00000;
    localparam logic [20:0] CP_TAB   = 21'h00009;
    localparam logic [20:0] CP_LF    = 21'h0000A;
    localparam logic [20:0] CP_CR    = 21'h0000D;
    localparam logic [20:0] CP_SPACE = 21'h00020;

    localparam logic [31:0] SUM_MAX = 32'hFFFF_FFFF;

    // One grapheme column as captured at the input.
    typedef struct packed {
        logic [31:0] text_bytes;
        logic [2:0]  byte_count;
        logic [15:0] first_column;
        logic [15:0] end_column;
        logic [19:0] first_byte_offset;
        logic [19:0] end_byte_offset;
        logic [15:0] first_glyph;
        logic [15:0] end_glyph;
        logic [31:0] width_advance;
        logic [31:0] pixel_advance;
        logic        final_column;
    } t_col;

    // One emitted direction run.
    typedef struct packed {
        logic        rtl;
        logic [15:0] first_column;
        logic [15:0] end_column;
        logic [19:0] first_byte;
        logic [19:0] end_byte;
        logic [15:0] first_glyph;
        logic [15:0] end_glyph;
        logic [31:0] width_sum;
        logic [31:0] pixel_sum;
        logic        last;
    } t_run;

    // Results written into the queue by one column.
    typedef struct packed {
        logic push_a;
        logic push_b;
    } t_push;

    // Unsigned add that sticks at all ones on overflow.
    function automatic logic [31:0] sat_add(input logic [31:0] a, input logic [31:0] b);
        logic [32:0] s;
        s = {1'b0, a} + {1'b0, b};
        return s[32] ? SUM_MAX : s[31:0];
    endfunction

endpackage

// ===== hw/rtl/bidi_direction_run_builder.sv =====
// ============================================================================
// bidi_direction_run_builder
// Splits a stream of grapheme columns into runs of one text direction.
// ============================================================================
// The input channel (i_in_valid / o_in_ready) carries one grapheme column per
// transaction, the output channel (o_out_valid / i_out_ready) one finished
// direction run. The base direction is a single register; the user writes it
// by i_cfg_wr_en / i_cfg_wr_data only while the block idles, unenforced by it.
//
// Throughput is one column per cycle while the queue has room for two runs.
// Each column is captured in an input register; once the queue has room it is
// classified and merged into the held run, and any finished runs go into a
// result queue, so a run reaches the output through the input register and
// the queue. A column yields zero, one or two runs; the input register only
// moves forward while the queue has room for two, which keeps the input side
// running as long as the receiver drains about one run per column.
//
// When the receiver stalls, the queue fills and o_in_ready drops once the
// input register holds a column that cannot be placed. Reset (synchronous,
// active low) empties the queue and the input register, drops the held run
// and sets the base direction to left-to-right.
// ============================================================================
module bidi_direction_run_builder #(
    parameter int unsigned QUEUE_DEPTH = bdrb_pkg::RB_QUEUE_DEPTH
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // Configuration
    input  logic        i_cfg_wr_en,
    input  logic        i_cfg_wr_data,
    // Column input
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic [31:0] i_text_bytes,
    input  logic [2:0]  i_byte_count,
    input  logic [15:0] i_first_column,
    input  logic [15:0] i_end_column,
    input  logic [19:0] i_first_byte_offset,
    input  logic [19:0] i_end_byte_offset,
    input  logic [15:0] i_first_glyph,
    input  logic [15:0] i_end_glyph,
    input  logic [31:0] i_width_advance,
    input  logic [31:0] i_pixel_advance,
    input  logic        i_final_column,
    // Run output
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic        o_run_rtl,
    output logic [15:0] o_run_first_column,
    output logic [15:0] o_run_end_column,
    output logic [19:0] o_run_first_byte,
    output logic [19:0] o_run_end_byte,
    output logic [15:0] o_run_first_glyph,
    output logic [15:0] o_run_end_glyph,
    output logic [31:0] o_run_width_sum,
    output logic [31:0] o_run_pixel_sum,
    output logic        o_last_run
);
    import bdrb_pkg::*;

    logic  r_base_rtl;
    logic  r_in_valid;
    logic  n_in_valid;
    t_col  r_in;
    logic  in_take;
    logic  advance;
    logic  space2;
    logic  dir;
    t_push push;
    t_run  run_a;
    t_run  run_b;
    t_run  run_out;

    // Base direction register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_base_rtl <= 1'b0;
        end else if (i_cfg_wr_en) begin
            r_base_rtl <= i_cfg_wr_data;
        end
    end

    // The input register hands its column on whenever the queue can take the
    // worst case of two runs, so a new transaction is taken in the same cycle.
    assign advance    = r_in_valid && space2;
    assign o_in_ready = !r_in_valid || space2;
    assign in_take    = i_in_valid && o_in_ready;
    assign n_in_valid = in_take ? 1'b1 : (advance ? 1'b0 : r_in_valid);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else begin
            r_in_valid <= n_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_in.text_bytes        <= i_text_bytes;
            r_in.byte_count        <= i_byte_count;
            r_in.first_column      <= i_first_column;
            r_in.end_column        <= i_end_column;
            r_in.first_byte_offset <= i_first_byte_offset;
            r_in.end_byte_offset   <= i_end_byte_offset;
            r_in.first_glyph       <= i_first_glyph;
            r_in.end_glyph         <= i_end_glyph;
            r_in.width_advance     <= i_width_advance;
            r_in.pixel_advance     <= i_pixel_advance;
            r_in.final_column      <= i_final_column;
        end
    end

    bdrb_classify u_classify (
        .i_text_bytes (r_in.text_bytes),
        .i_byte_count (r_in.byte_count),
        .i_base_rtl   (r_base_rtl),
        .o_rtl        (dir)
    );

    bdrb_merge u_merge (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_fire  (advance),
        .i_col   (r_in),
        .i_dir   (dir),
        .o_push  (push),
        .o_run_a (run_a),
        .o_run_b (run_b)
    );

    bdrb_run_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (push),
        .i_run_a  (run_a),
        .i_run_b  (run_b),
        .o_space2 (space2),
        .o_valid  (o_out_valid),
        .i_ready  (i_out_ready),
        .o_run    (run_out)
    );

    assign o_run_rtl          = run_out.rtl;
    assign o_run_first_column = run_out.first_column;
    assign o_run_end_column   = run_out.end_column;
    assign o_run_first_byte   = run_out.first_byte;
    assign o_run_end_byte     = run_out.end_byte;
    assign o_run_first_glyph  = run_out.first_glyph;
    assign o_run_end_glyph    = run_out.end_glyph;
    assign o_run_width_sum    = run_out.width_sum;
    assign o_run_pixel_sum    = run_out.pixel_sum;
    assign o_last_run         = run_out.last;

endmodule

// ===== hw/rtl/bdrb_classify.sv =====
// ============================================================================
// bdrb_classify
// Decodes the lead code point of a column and derives its direction.
// ============================================================================
module bdrb_classify (
    input  logic [31:0] i_text_bytes,
    input  logic [2:0]  i_byte_count,
    input  logic        i_base_rtl,
    output logic        o_rtl
);
    import bdrb_pkg::*;

    logic [7:0]  b0;
    logic [5:0]  b1;
    logic [5:0]  b2;
    logic [5:0]  b3;
    logic [20:0] cp;
    logic        in_rtl_range;
    logic        is_neutral;

    assign b0 = i_text_bytes[7:0];
    assign b1 = i_text_bytes[13:8];
    assign b2 = i_text_bytes[21:16];
    assign b3 = i_text_bytes[29:24];

    // Counts of four and above all use the four-byte form.
    always_comb begin
        priority if (i_byte_count == 3'd0) begin
            cp = '0;
        end else if (!b0[7] || i_byte_count == 3'd1) begin
            cp = {13'd0, b0};
        end else if (i_byte_count == 3'd2) begin
            cp = {10'd0, b0[4:0], b1};
        end else if (i_byte_count == 3'd3) begin
            cp = {5'd0, b0[3:0], b1, b2};
        end else begin
            cp = {b0[2:0], b1, b2, b3};
        end
    end

    assign in_rtl_range = (cp >= CP_HEB_ARAB_LO && cp <= CP_HEB_ARAB_HI)
                       || (cp >= CP_PRES_A_LO && cp <= CP_PRES_A_HI)
                       || (cp >= CP_PRES_B_LO && cp <= CP_PRES_B_HI);

    assign is_neutral = (cp == CP_NUL) || (cp == CP_TAB) || (cp == CP_LF)
                     || (cp == CP_CR) || (cp == CP_SPACE);

    assign o_rtl = in_rtl_range | (is_neutral & i_base_rtl);

endmodule

// ===== hw/rtl/bdrb_merge.sv =====
// ============================================================================
// bdrb_merge
// Holds the open run, extends it with each column and forms finished runs.
// ============================================================================
module bdrb_merge (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_fire,
    input  bdrb_pkg::t_col i_col,
    input  logic           i_dir,
    output bdrb_pkg::t_push o_push,
    output bdrb_pkg::t_run o_run_a,
    output bdrb_pkg::t_run o_run_b
);
    import bdrb_pkg::*;

    logic r_held_valid;
    logic n_held_valid;
    t_run r_held;
    t_run n_held;
    logic change;
    logic start;

    assign change = r_held_valid && (r_held.rtl != i_dir);
    assign start  = !r_held_valid || change;

    // The held run after this column is merged in.
    always_comb begin
        n_held              = r_held;
        n_held.last         = 1'b1;
        n_held.end_column   = i_col.end_column;
        n_held.end_byte     = i_col.end_byte_offset;
        n_held.end_glyph    = i_col.end_glyph;
        if (start) begin
            n_held.rtl          = i_dir;
            n_held.first_column = i_col.first_column;
            n_held.first_byte   = i_col.first_byte_offset;
            n_held.first_glyph  = i_col.first_glyph;
            n_held.width_sum    = i_col.width_advance;
            n_held.pixel_sum    = i_col.pixel_advance;
        end else begin
            n_held.width_sum    = sat_add(r_held.width_sum, i_col.width_advance);
            n_held.pixel_sum    = sat_add(r_held.pixel_sum, i_col.pixel_advance);
        end
    end

    always_comb begin
        o_run_a      = n_held;
        o_run_b      = n_held;
        if (change) begin
            o_run_a      = r_held;
            o_run_a.last = 1'b0;
        end
        o_push.push_a = i_fire && (change || i_col.final_column);
        o_push.push_b = i_fire && change && i_col.final_column;
    end

    assign n_held_valid = i_fire ? !i_col.final_column : r_held_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_held_valid <= 1'b0;
        end else begin
            r_held_valid <= n_held_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_fire) begin
            r_held <= n_held;
        end
    end

endmodule

// ===== hw/rtl/bdrb_run_queue.sv =====
// ============================================================================
// bdrb_run_queue
// Small result queue that takes up to two runs a cycle and gives one.
// ============================================================================
module bdrb_run_queue #(
    parameter int unsigned DEPTH = bdrb_pkg::RB_QUEUE_DEPTH
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  bdrb_pkg::t_push i_push,
    input  bdrb_pkg::t_run  i_run_a,
    input  bdrb_pkg::t_run  i_run_b,
    output logic            o_space2,
    output logic            o_valid,
    input  logic            i_ready,
    output bdrb_pkg::t_run  o_run
);
    import bdrb_pkg::*;

    localparam int unsigned PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CW = $clog2(DEPTH + 1);

    function automatic logic [PW-1:0] ptr_inc(input logic [PW-1:0] p);
        return (p == PW'(DEPTH - 1)) ? '0 : p + 1'b1;
    endfunction

    t_run          r_mem [DEPTH];
    logic [PW-1:0] r_wr_ptr;
    logic [PW-1:0] n_wr_ptr;
    logic [PW-1:0] r_rd_ptr;
    logic [PW-1:0] n_rd_ptr;
    logic [CW-1:0] r_count;
    logic [CW-1:0] n_count;
    logic [PW-1:0] wr_ptr_b;
    logic          pop;

    assign wr_ptr_b = ptr_inc(r_wr_ptr);
    assign pop      = o_valid && i_ready;
    assign o_valid  = (r_count != '0);
    assign o_run    = r_mem[r_rd_ptr];
    assign o_space2 = (r_count <= CW'(DEPTH - 2));

    always_comb begin
        n_wr_ptr = r_wr_ptr;
        if (i_push.push_b) begin
            n_wr_ptr = ptr_inc(wr_ptr_b);
        end else if (i_push.push_a) begin
            n_wr_ptr = wr_ptr_b;
        end
        n_rd_ptr = pop ? ptr_inc(r_rd_ptr) : r_rd_ptr;
        n_count  = r_count + CW'(i_push.push_a) + CW'(i_push.push_b) - CW'(pop);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push.push_a) begin
            r_mem[r_wr_ptr] <= i_run_a;
        end
        if (i_push.push_b) begin
            r_mem[wr_ptr_b] <= i_run_b;
        end
    end

endmodule

// ===== hw/rtl/bdrb_checker.sv =====
// ============================================================================
// bdrb_checker
// Port-level checks for the direction run builder, bound to the top level.
// ============================================================================
module bdrb_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        o_in_ready,
    input logic        o_out_valid,
    input logic        i_out_ready,
    input logic        o_run_rtl,
    input logic [15:0] o_run_first_column,
    input logic [31:0] o_run_width_sum,
    input logic        o_last_run
);

    // Reset leaves nothing to send and room to take a transaction.
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid && o_in_ready)
        else $error("output not empty or input not ready after reset");

    // The input only backs up when runs are waiting at the output.
    a_stall_has_output: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_in_ready |-> o_out_valid)
        else $error("input stalled with no run waiting");

    // A run that is not the last one was closed by a change of direction.
    a_direction_alternates: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_ready && !o_last_run |=>
            !o_out_valid || (o_run_rtl != $past(o_run_rtl)))
        else $error("consecutive runs share a direction");

    // A waiting run holds until the transaction completes.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=>
            o_out_valid && $stable(o_run_rtl) && $stable(o_run_first_column)
            && $stable(o_run_width_sum) && $stable(o_last_run))
        else $error("waiting run changed before its transaction");

endmodule

bind bidi_direction_run_builder bdrb_checker u_bdrb_checker (.*);
